// File: src/seg_pkg.sv
// Shared types and constants for the segment intersection block.
package seg_pkg;

  // Default coordinate width
  localparam int COORD_BITS_DEF = 16;

  // Result codes
  typedef enum logic [1:0] {
    OUT_NONE      = 2'd0,
    OUT_HIT       = 2'd1,
    OUT_COLLINEAR = 2'd2
  } outcome_t;

  // Control word that travels with each request down the pipe
  typedef struct packed {
    logic     valid;
    outcome_t outcome;
    logic     use_div;
    logic     neg_x;
    logic     neg_y;
  } seg_ctrl_t;

endpackage

// File: src/seg_front.sv
// Front pipeline: line equations, side tests, denominator and numerators.
module seg_front #(
  parameter int COORD_BITS = seg_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req,
  input  logic signed [COORD_BITS-1:0]  x1,
  input  logic signed [COORD_BITS-1:0]  y1,
  input  logic signed [COORD_BITS-1:0]  x2,
  input  logic signed [COORD_BITS-1:0]  y2,
  input  logic signed [COORD_BITS-1:0]  x3,
  input  logic signed [COORD_BITS-1:0]  y3,
  input  logic signed [COORD_BITS-1:0]  x4,
  input  logic signed [COORD_BITS-1:0]  y4,
  output seg_pkg::seg_ctrl_t            ctrl_out,
  output logic [COORD_BITS-1:0]         px_out,
  output logic [COORD_BITS-1:0]         py_out,
  output logic [2*COORD_BITS+1:0]       d_out,
  output logic [3*COORD_BITS+1:0]       rx_out,
  output logic [3*COORD_BITS+1:0]       ry_out
);
  import seg_pkg::*;

  localparam int W   = COORD_BITS;
  localparam int DW  = W + 1;
  localparam int PW  = 2 * W;
  localparam int CW  = 2 * W + 1;
  localparam int PPW = 2 * W + 2;
  localparam int SW  = 2 * W + 3;
  localparam int NW  = 3 * W + 2;
  localparam int DD  = 2 * W + 2;

  // Stage A: coordinate differences and the corner products
  logic                 va;
  logic signed [DW-1:0] a1, b1, a2, b2;
  logic signed [DW-1:0] dx31, dy31, dx41, dy41, dx13, dy13, dx23, dy23;
  logic signed [PW-1:0] pa, pb, pc, pd;
  logic signed [W-1:0]  mxa, nxa, nya;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= req;
    end
    a1   <= DW'(y2) - DW'(y1);
    b1   <= DW'(x1) - DW'(x2);
    a2   <= DW'(y4) - DW'(y3);
    b2   <= DW'(x3) - DW'(x4);
    dx31 <= DW'(x3) - DW'(x1);
    dy31 <= DW'(y3) - DW'(y1);
    dx41 <= DW'(x4) - DW'(x1);
    dy41 <= DW'(y4) - DW'(y1);
    dx13 <= DW'(x1) - DW'(x3);
    dy13 <= DW'(y1) - DW'(y3);
    dx23 <= DW'(x2) - DW'(x3);
    dy23 <= DW'(y2) - DW'(y3);
    pa   <= PW'(x2) * PW'(y1);
    pb   <= PW'(x1) * PW'(y2);
    pc   <= PW'(x4) * PW'(y3);
    pd   <= PW'(x3) * PW'(y4);
    mxa  <= (x1 > x2) ? x1 : x2;
    nxa  <= (x3 < x4) ? x3 : x4;
    nya  <= (y3 < y4) ? y3 : y4;
  end

  // Stage B: side-test products, denominator products, line constants
  logic                  vb, col_b;
  logic signed [PPW-1:0] m3a, m3b, m4a, m4b, m1a, m1b, m2a, m2b, dn1, dn2;
  logic signed [CW-1:0]  c1, c2;
  logic signed [DW-1:0]  a1b, b1b, a2b, b2b;
  logic signed [W-1:0]   nxb, nyb;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else begin
      vb <= va;
    end
    m3a   <= PPW'(a1) * PPW'(dx31);
    m3b   <= PPW'(b1) * PPW'(dy31);
    m4a   <= PPW'(a1) * PPW'(dx41);
    m4b   <= PPW'(b1) * PPW'(dy41);
    m1a   <= PPW'(a2) * PPW'(dx13);
    m1b   <= PPW'(b2) * PPW'(dy13);
    m2a   <= PPW'(a2) * PPW'(dx23);
    m2b   <= PPW'(b2) * PPW'(dy23);
    dn1   <= PPW'(a1) * PPW'(b2);
    dn2   <= PPW'(a2) * PPW'(b1);
    c1    <= CW'(pa) - CW'(pb);
    c2    <= CW'(pc) - CW'(pd);
    a1b   <= a1;
    b1b   <= b1;
    a2b   <= a2;
    b2b   <= b2;
    col_b <= nxa < mxa;
    nxb   <= nxa;
    nyb   <= nya;
  end

  // Stage C: side sums and rejection; numerator partial products
  logic signed [SW-1:0]  s1, s2, s3, s4;
  logic signed [DW-1:0]  c1hi, c2hi, c1lo, c2lo;
  logic                  vc, col_c, rej_c;
  logic signed [SW-1:0]  den_c;
  logic signed [PPW-1:0] qa, qb, qc, qd, ra, rb, rc, rd;
  logic signed [W-1:0]   nxc, nyc;

  always_comb begin
    s3   = SW'(m3a) + SW'(m3b);
    s4   = SW'(m4a) + SW'(m4b);
    s1   = SW'(m1a) + SW'(m1b);
    s2   = SW'(m2a) + SW'(m2b);
    c1hi = c1[CW-1:W];
    c2hi = c2[CW-1:W];
    c1lo = {1'b0, c1[W-1:0]};
    c2lo = {1'b0, c2[W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else begin
      vc <= vb;
    end
    rej_c <= ((s3 != '0) && (s4 != '0) && (s3[SW-1] == s4[SW-1])) ||
             ((s1 != '0) && (s2 != '0) && (s1[SW-1] == s2[SW-1]));
    den_c <= SW'(dn1) - SW'(dn2);
    qa    <= PPW'(b1b) * PPW'(c2hi);
    qb    <= PPW'(b1b) * PPW'(c2lo);
    qc    <= PPW'(b2b) * PPW'(c1hi);
    qd    <= PPW'(b2b) * PPW'(c1lo);
    ra    <= PPW'(a2b) * PPW'(c1hi);
    rb    <= PPW'(a2b) * PPW'(c1lo);
    rc    <= PPW'(a1b) * PPW'(c2hi);
    rd    <= PPW'(a1b) * PPW'(c2lo);
    col_c <= col_b;
    nxc   <= nxb;
    nyc   <= nyb;
  end

  // Stage D: numerators, denominator magnitude, outcome decision
  seg_ctrl_t            ctrl_d, ctrl_d_next;
  logic signed [NW-1:0] num_x, num_y;
  logic [DD-1:0]        dabs;
  logic                 den_neg;
  logic [W-1:0]         px_d, py_d, px_d_next, py_d_next;

  always_comb begin
    ctrl_d_next       = '0;
    ctrl_d_next.valid = vc;
    px_d_next         = '0;
    py_d_next         = '0;
    priority if (rej_c) begin
      ctrl_d_next.outcome = OUT_NONE;
    end else if (den_c == '0) begin
      if (col_c) begin
        ctrl_d_next.outcome = OUT_HIT;
        px_d_next           = nxc;
        py_d_next           = nyc;
      end else begin
        ctrl_d_next.outcome = OUT_COLLINEAR;
      end
    end else begin
      ctrl_d_next.outcome = OUT_HIT;
      ctrl_d_next.use_div = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_d <= '0;
    end else begin
      ctrl_d <= ctrl_d_next;
    end
    num_x   <= ((NW'(qa) - NW'(qc)) <<< W) + NW'(qb) - NW'(qd);
    num_y   <= ((NW'(ra) - NW'(rc)) <<< W) + NW'(rb) - NW'(rd);
    dabs    <= den_c[SW-1] ? DD'(-den_c) : DD'(den_c);
    den_neg <= den_c[SW-1];
    px_d    <= px_d_next;
    py_d    <= py_d_next;
  end

  // Stage E: numerator magnitudes, result signs, half divisor
  seg_ctrl_t     ctrl_e, ctrl_e_next;
  logic [NW-1:0] nabs_x, nabs_y;
  logic [DD-1:0] dabs_e, half_e;
  logic [W-1:0]  px_e, py_e;

  always_comb begin
    ctrl_e_next       = ctrl_d;
    ctrl_e_next.neg_x = num_x[NW-1] ^ den_neg;
    ctrl_e_next.neg_y = num_y[NW-1] ^ den_neg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_e <= '0;
    end else begin
      ctrl_e <= ctrl_e_next;
    end
    nabs_x <= num_x[NW-1] ? NW'(-num_x) : NW'(num_x);
    nabs_y <= num_y[NW-1] ? NW'(-num_y) : NW'(num_y);
    dabs_e <= dabs;
    half_e <= dabs >> 1;
    px_e   <= px_d;
    py_e   <= py_d;
  end

  // Stage F: rounding offset added to the magnitudes
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out <= '0;
    end else begin
      ctrl_out <= ctrl_e;
    end
    rx_out <= nabs_x + NW'(half_e);
    ry_out <= nabs_y + NW'(half_e);
    d_out  <= dabs_e;
    px_out <= px_e;
    py_out <= py_e;
  end

endmodule

// File: src/seg_div_cell.sv
// One restoring-division cell: settles one quotient bit of x and of y.
module seg_div_cell #(
  parameter int COORD_BITS = seg_pkg::COORD_BITS_DEF,
  parameter int SHIFT      = 0
) (
  input  logic                    clk,
  input  logic                    rst,
  input  seg_pkg::seg_ctrl_t      ctrl_in,
  input  logic [COORD_BITS-1:0]   px_in,
  input  logic [COORD_BITS-1:0]   py_in,
  input  logic [2*COORD_BITS+1:0] d_in,
  input  logic [3*COORD_BITS+1:0] rx_in,
  input  logic [3*COORD_BITS+1:0] ry_in,
  input  logic [COORD_BITS-1:0]   qx_in,
  input  logic [COORD_BITS-1:0]   qy_in,
  output seg_pkg::seg_ctrl_t      ctrl_out,
  output logic [COORD_BITS-1:0]   px_out,
  output logic [COORD_BITS-1:0]   py_out,
  output logic [2*COORD_BITS+1:0] d_out,
  output logic [3*COORD_BITS+1:0] rx_out,
  output logic [3*COORD_BITS+1:0] ry_out,
  output logic [COORD_BITS-1:0]   qx_out,
  output logic [COORD_BITS-1:0]   qy_out
);
  import seg_pkg::*;

  localparam int NW = 3 * COORD_BITS + 2;

  logic [NW-1:0]         dsh;
  logic                  ge_x, ge_y;
  logic [COORD_BITS-1:0] qx_set, qy_set;

  // Trial subtract of the shifted divisor
  always_comb begin
    dsh  = NW'(d_in) << SHIFT;
    ge_x = rx_in >= dsh;
    ge_y = ry_in >= dsh;
    qx_set        = qx_in;
    qy_set        = qy_in;
    qx_set[SHIFT] = ge_x;
    qy_set[SHIFT] = ge_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out <= '0;
    end else begin
      ctrl_out <= ctrl_in;
    end
    px_out <= px_in;
    py_out <= py_in;
    d_out  <= d_in;
    rx_out <= ge_x ? rx_in - dsh : rx_in;
    ry_out <= ge_y ? ry_in - dsh : ry_in;
    qx_out <= qx_set;
    qy_out <= qy_set;
  end

endmodule

// File: src/segment_intersection.sv
// Top level of the integer line segment intersection block.
//
// Usage: drive the eight endpoint coordinates and raise start; a request is
// taken at each clock edge where start is high and busy is low. busy is high
// only while rst is asserted, so one request may be issued every cycle.
// Each request yields exactly one result: done pulses for one cycle with
// outcome (none, hit, collinear) and the rounded crossing point cross_x,
// cross_y, which read zero unless outcome is hit.
// The pipe runs from the accepting edge to the edge that
// ends the done cycle: six front stages (differences, products, side tests,
// numerators, magnitudes, rounding offset), one division cell per quotient
// bit, and the output register. Throughput is one request per cycle; the
// division row is the long part of the pipe, one bit per cell.
// Results are presented for one cycle only; the receiver cannot hold them
// off and must take each one as it appears.
// Reset is synchronous: it empties the pipe, so requests in flight are
// dropped and no done pulse follows for them.
module segment_intersection #(
  parameter int COORD_BITS = seg_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] seg1_start_x,
  input  logic signed [COORD_BITS-1:0] seg1_start_y,
  input  logic signed [COORD_BITS-1:0] seg1_end_x,
  input  logic signed [COORD_BITS-1:0] seg1_end_y,
  input  logic signed [COORD_BITS-1:0] seg2_start_x,
  input  logic signed [COORD_BITS-1:0] seg2_start_y,
  input  logic signed [COORD_BITS-1:0] seg2_end_x,
  input  logic signed [COORD_BITS-1:0] seg2_end_y,
  output logic                         done,
  output logic [1:0]                   outcome,
  output logic signed [COORD_BITS-1:0] cross_x,
  output logic signed [COORD_BITS-1:0] cross_y
);
  import seg_pkg::*;

  localparam int W  = COORD_BITS;
  localparam int NW = 3 * W + 2;
  localparam int DD = 2 * W + 2;

  seg_ctrl_t     ctrl [W+1];
  logic [W-1:0]  px   [W+1];
  logic [W-1:0]  py   [W+1];
  logic [DD-1:0] dv   [W+1];
  logic [NW-1:0] rx   [W+1];
  logic [NW-1:0] ry   [W+1];
  logic [W-1:0]  qx   [W+1];
  logic [W-1:0]  qy   [W+1];

  assign busy  = rst;
  assign qx[0] = '0;
  assign qy[0] = '0;

  // Geometry front end
  seg_front #(.COORD_BITS(W)) u_front (
    .clk      (clk),
    .rst      (rst),
    .req      (start & ~busy),
    .x1       (seg1_start_x),
    .y1       (seg1_start_y),
    .x2       (seg1_end_x),
    .y2       (seg1_end_y),
    .x3       (seg2_start_x),
    .y3       (seg2_start_y),
    .x4       (seg2_end_x),
    .y4       (seg2_end_y),
    .ctrl_out (ctrl[0]),
    .px_out   (px[0]),
    .py_out   (py[0]),
    .d_out    (dv[0]),
    .rx_out   (rx[0]),
    .ry_out   (ry[0])
  );

  // Division row, most significant quotient bit first
  for (genvar k = 0; k < W; k++) begin : g_cell
    seg_div_cell #(.COORD_BITS(W), .SHIFT(W - 1 - k)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl_in  (ctrl[k]),
      .px_in    (px[k]),
      .py_in    (py[k]),
      .d_in     (dv[k]),
      .rx_in    (rx[k]),
      .ry_in    (ry[k]),
      .qx_in    (qx[k]),
      .qy_in    (qy[k]),
      .ctrl_out (ctrl[k+1]),
      .px_out   (px[k+1]),
      .py_out   (py[k+1]),
      .d_out    (dv[k+1]),
      .rx_out   (rx[k+1]),
      .ry_out   (ry[k+1]),
      .qx_out   (qx[k+1]),
      .qy_out   (qy[k+1])
    );
  end

  // Output register: apply quotient sign or pass the direct point
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl[W].valid;
    end
    outcome <= ctrl[W].outcome;
    if (ctrl[W].use_div) begin
      cross_x <= ctrl[W].neg_x ? -qx[W] : qx[W];
      cross_y <= ctrl[W].neg_y ? -qy[W] : qy[W];
    end else begin
      cross_x <= px[W];
      cross_y <= py[W];
    end
  end

endmodule

// File: src/seg_checker.sv
// Port-level checks for the segment intersection block, bound to the top.
module seg_checker #(
  parameter int COORD_BITS = seg_pkg::COORD_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input logic                  done,
  input logic [1:0]            outcome,
  input logic [COORD_BITS-1:0] cross_x,
  input logic [COORD_BITS-1:0] cross_y
);
  import seg_pkg::*;

  localparam int LAT = COORD_BITS + 7;

  // Every request produces a result after the fixed latency
  a_req_done : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("request without result");

  // No result without a matching request
  a_done_req : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without request");

  // Outcome is a defined code
  a_code : assert property (@(posedge clk) disable iff (rst)
    done |-> (outcome == OUT_NONE || outcome == OUT_HIT || outcome == OUT_COLLINEAR))
    else $error("undefined outcome");

  // Point is zero unless a hit is reported
  a_zero : assert property (@(posedge clk) disable iff (rst)
    (done && outcome != OUT_HIT) |-> (cross_x == '0 && cross_y == '0))
    else $error("point set without hit");

endmodule

bind segment_intersection seg_checker #(.COORD_BITS(COORD_BITS)) u_seg_checker (.*);
